// ===== sv/nonpreemptive_priority_scheduler_macros.svh =====
// Assertion macros for the non-preemptive priority scheduler.
// Used by the top level; expects clk and arst_n in scope.
`ifndef NONPREEMPTIVE_PRIORITY_SCHEDULER_MACROS_SVH
`define NONPREEMPTIVE_PRIORITY_SCHEDULER_MACROS_SVH

// The property must hold in the same cycle as its trigger.
`define NPS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The property must hold in the cycle after its trigger.
`define NPS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/nps_pkg.sv =====
// Shared types, sizes and helpers for the non-preemptive priority scheduler.
// No dependencies.
`timescale 1ns / 1ps

package nps_pkg;
	localparam int MAX_JOBS = 16;
	localparam int IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
	localparam int CNT_W = $clog2(MAX_JOBS + 1);
	localparam int TICK_W = 24;
	localparam int SUM_W = 28;

	typedef struct packed {
		logic             valid;
		logic             done;
		logic [IDX_W-1:0] idx;
		logic [15:0]      id;
		logic [15:0]      arr;
		logic [15:0]      burst;
		logic [7:0]       prio;
	} job_t;

	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] idx;
		logic [15:0]      id;
		logic [15:0]      arr;
		logic [15:0]      burst;
		logic [7:0]       prio;
		logic             pend;
		logic [15:0]      min_arr;
	} pick_t;

	function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
			input logic [TICK_W-1:0] b);
		logic [SUM_W:0] s;
		s = {1'b0, a} + {{(SUM_W + 1 - TICK_W){1'b0}}, b};
		return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
	endfunction
endpackage

// ===== sv/nps_cell.sv =====
// One job slot of the scheduler ring; takes its neighbor's job when enabled.
// Depends on nps_pkg.
`timescale 1ns / 1ps

module nps_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          clr,
	input  nps_pkg::job_t d,
	output nps_pkg::job_t q
);
	import nps_pkg::*;

	logic valid_q;
	job_t data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (clr) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= d.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= d;
		end
	end

	always_comb begin
		q = data_q;
		q.valid = valid_q;
	end
endmodule

// ===== sv/nps_pick.sv =====
// Scan unit: looks at one job per cycle as the ring turns and keeps the best
// ready job and the earliest pending arrival. Depends on nps_pkg.
`timescale 1ns / 1ps

module nps_pick (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       first,
	input  nps_pkg::job_t              tap,
	input  logic [nps_pkg::TICK_W-1:0] tick,
	output nps_pkg::pick_t             best
);
	import nps_pkg::*;

	pick_t cur, nxt;
	logic  ready, pending, better;

	assign cur = first ? '0 : best;
	assign pending = tap.valid && !tap.done;
	assign ready = pending && ({{(TICK_W - 16){1'b0}}, tap.arr} <= tick);
	// Lower priority number wins, then earlier arrival, then earlier load.
	assign better = !cur.found || (tap.prio < cur.prio) ||
		(tap.prio == cur.prio && (tap.arr < cur.arr ||
		(tap.arr == cur.arr && tap.idx < cur.idx)));

	always_comb begin
		nxt = cur;
		if (ready && better) begin
			nxt.found = 1'b1;
			nxt.idx = tap.idx;
			nxt.id = tap.id;
			nxt.arr = tap.arr;
			nxt.burst = tap.burst;
			nxt.prio = tap.prio;
		end
		if (pending && (!cur.pend || tap.arr < cur.min_arr)) begin
			nxt.pend = 1'b1;
			nxt.min_arr = tap.arr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best <= '0;
		end else if (en) begin
			best <= nxt;
		end
	end
endmodule

// ===== sv/nonpreemptive_priority_scheduler.sv =====
// Non-preemptive priority scheduler: a ring of job cells, a scan unit and the
// control that emits one record per job. Depends on nps_pkg, nps_cell, nps_pick.
//
//   channel | handshake            | direction | payload
//   in      | in_valid / in_ready  | input     | job_id .. final_job
//   out     | out_valid / out_ready| output    | job_id_res .. last_record
//
// Loading takes one job per cycle while no schedule runs. For each record the
// ring turns once past the scan unit, then the control decides; a decision
// with no ready job costs another pass after the tick jumps ahead.
// Reset empties the ring. A stalled output holds the decision state.
`timescale 1ns / 1ps
`include "nonpreemptive_priority_scheduler_macros.svh"

module nonpreemptive_priority_scheduler (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] job_id,
	input  logic [15:0] arrival_time,
	input  logic [15:0] burst_length,
	input  logic [7:0]  priority_level,
	input  logic        final_job,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] job_id_res,
	output logic [23:0] start_time,
	output logic [23:0] finish_time,
	output logic [23:0] wait_time,
	output logic [23:0] turnaround,
	output logic [23:0] response,
	output logic [27:0] sum_wait,
	output logic [27:0] sum_turnaround,
	output logic [27:0] sum_response,
	output logic [6:0]  job_count,
	output logic        last_record
);
	import nps_pkg::*;

	typedef enum logic [1:0] {ST_LOAD, ST_SCAN, ST_DECIDE} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  count_q, n_q, k_q, k_next;
	logic [IDX_W-1:0]  cnt_q, mark_idx_q;
	logic              mark_v_q;
	logic [TICK_W-1:0] tick_q, finish, resp, turn;
	logic [SUM_W-1:0]  sw_q, st_q, sr_q;
	job_t              ring [MAX_JOBS];
	job_t              tap, head_d;
	pick_t             best;
	logic              load_shift, ring_en, out_free, commit, batch_done;

	assign in_ready = (state_q == ST_LOAD);
	assign load_shift = in_valid && in_ready && (count_q < CNT_W'(MAX_JOBS));
	assign ring_en = load_shift || (state_q == ST_SCAN);

	// The last decided job is marked done as it passes the scan point.
	always_comb begin
		tap = ring[MAX_JOBS-1];
		if (mark_v_q && tap.idx == mark_idx_q) begin
			tap.done = 1'b1;
		end
		if (state_q == ST_LOAD) begin
			head_d.valid = 1'b1;
			head_d.done = 1'b0;
			head_d.idx = count_q[IDX_W-1:0];
			head_d.id = job_id;
			head_d.arr = arrival_time;
			head_d.burst = burst_length;
			head_d.prio = priority_level;
		end else begin
			head_d = tap;
		end
	end

	assign out_free = !out_valid || out_ready;
	assign commit = (state_q == ST_DECIDE) && best.found && out_free;
	assign k_next = k_q + 1'b1;
	assign batch_done = commit && (k_next == n_q);

	genvar g;
	generate
		for (g = 0; g < MAX_JOBS; g++) begin : g_cell
			nps_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.en     (ring_en),
				.clr    (batch_done),
				.d      ((g == 0) ? head_d : ring[(g == 0) ? 0 : g - 1]),
				.q      (ring[g])
			);
		end
	endgenerate

	nps_pick u_pick (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (state_q == ST_SCAN),
		.first  (cnt_q == '0),
		.tap    (tap),
		.tick   (tick_q),
		.best   (best)
	);

	assign finish = tick_q + {{(TICK_W - 16){1'b0}}, best.burst};
	assign resp = tick_q - {{(TICK_W - 16){1'b0}}, best.arr};
	assign turn = finish - {{(TICK_W - 16){1'b0}}, best.arr};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			count_q <= '0;
			n_q <= '0;
			k_q <= '0;
			cnt_q <= '0;
			mark_v_q <= 1'b0;
			mark_idx_q <= '0;
			tick_q <= '0;
			sw_q <= '0;
			st_q <= '0;
			sr_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (commit) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (load_shift) begin
						count_q <= count_q + 1'b1;
					end
					if (in_valid && final_job) begin
						n_q <= load_shift ? count_q + 1'b1 : count_q;
						k_q <= '0;
						cnt_q <= '0;
						mark_v_q <= 1'b0;
						tick_q <= '0;
						sw_q <= '0;
						st_q <= '0;
						sr_q <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (cnt_q == IDX_W'(MAX_JOBS - 1)) begin
						cnt_q <= '0;
						state_q <= ST_DECIDE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DECIDE: begin
					if (!best.found) begin
						tick_q <= {{(TICK_W - 16){1'b0}}, best.min_arr};
						state_q <= ST_SCAN;
					end else if (commit) begin
						job_id_res <= best.id;
						start_time <= tick_q;
						finish_time <= finish;
						wait_time <= resp;
						turnaround <= turn;
						response <= resp;
						sum_wait <= sat_add(sw_q, resp);
						sum_turnaround <= sat_add(st_q, turn);
						sum_response <= sat_add(sr_q, resp);
						job_count <= 7'(k_next);
						last_record <= batch_done;
						sw_q <= sat_add(sw_q, resp);
						st_q <= sat_add(st_q, turn);
						sr_q <= sat_add(sr_q, resp);
						tick_q <= finish;
						mark_v_q <= 1'b1;
						mark_idx_q <= best.idx;
						k_q <= k_next;
						if (batch_done) begin
							count_q <= '0;
							state_q <= ST_LOAD;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	`NPS_ASSERT_NEXT(a_final_starts, in_valid && in_ready && final_job, !in_ready, "final job did not start a schedule")
	`NPS_ASSERT_NOW(a_count_nonzero, out_valid, job_count != 7'd0, "record carries zero job count")
	`NPS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(job_id_res) && $stable(job_count), "record changed while stalled")
endmodule

// ===== verif/tb_nonpreemptive_priority_scheduler.sv =====
// Self-checking testbench for the non-preemptive priority scheduler.
// Depends on nps_pkg and nonpreemptive_priority_scheduler; predicts each record in place.
`timescale 1ns / 1ps

module tb_nonpreemptive_priority_scheduler;
	import nps_pkg::*;

	typedef struct packed {
		logic [15:0] id;
		logic [23:0] start;
		logic [23:0] finish;
		logic [23:0] wait_t;
		logic [23:0] turn;
		logic [23:0] resp;
		logic [27:0] s_wait;
		logic [27:0] s_turn;
		logic [27:0] s_resp;
		logic [6:0]  count;
		logic        last;
	} sched_rec_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [15:0] job_id = '0;
	logic [15:0] arrival_time = '0;
	logic [15:0] burst_length = '0;
	logic [7:0]  priority_level = '0;
	logic        final_job = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [15:0] job_id_res;
	logic [23:0] start_time, finish_time, wait_time, turnaround, response;
	logic [27:0] sum_wait, sum_turnaround, sum_response;
	logic [6:0]  job_count;
	logic        last_record;

	// Jobs of the batch being loaded, in load order.
	logic [15:0] batch_id [MAX_JOBS];
	logic [15:0] batch_arr [MAX_JOBS];
	logic [15:0] batch_burst [MAX_JOBS];
	logic [7:0]  batch_prio [MAX_JOBS];
	int          batch_len = 0;

	sched_rec_t  pending_recs[$];
	int          errors = 0;
	int          jobs_sent = 0;
	int          recs_seen = 0;
	int          batches_run = 0;
	int          stall_cycles = 0;
	bit          send_busy_free = 1'b0;
	bit          recv_busy_free = 1'b0;

	always #5 clk = ~clk;

	nonpreemptive_priority_scheduler DUT (.*);

	function automatic logic [27:0] sat_sum(logic [27:0] acc, logic [23:0] v);
		logic [28:0] s;
		s = {1'b0, acc} + 29'(v);
		return s[28] ? 28'hFFFFFFF : s[27:0];
	endfunction

	// Runs the whole schedule of the loaded batch and queues its records.
	function automatic void schedule_batch();
		bit          finished [MAX_JOBS];
		logic [23:0] tick, nxt;
		logic [27:0] sw, st, sr;
		sched_rec_t  r;
		int          best;
		tick = '0; sw = '0; st = '0; sr = '0;
		foreach (finished[i]) finished[i] = 1'b0;
		for (int k = 0; k < batch_len; k++) begin
			for (int pass = 0; pass < 2; pass++) begin
				best = -1;
				for (int i = 0; i < batch_len; i++) begin
					if (finished[i] || 24'(batch_arr[i]) > tick)
						continue;
					if (best < 0 || batch_prio[i] < batch_prio[best] ||
							(batch_prio[i] == batch_prio[best] &&
							batch_arr[i] < batch_arr[best]))
						best = i;
				end
				if (best >= 0)
					break;
				// Nothing ready: jump to the earliest pending arrival.
				nxt = 24'hFFFFFF;
				for (int i = 0; i < batch_len; i++)
					if (!finished[i] && 24'(batch_arr[i]) < nxt)
						nxt = 24'(batch_arr[i]);
				tick = nxt;
			end
			r.id = batch_id[best];
			r.start = tick;
			r.finish = tick + 24'(batch_burst[best]);
			r.resp = tick - 24'(batch_arr[best]);
			r.wait_t = r.resp;
			r.turn = r.finish - 24'(batch_arr[best]);
			sw = sat_sum(sw, r.resp);
			st = sat_sum(st, r.turn);
			sr = sat_sum(sr, r.resp);
			r.s_wait = sw; r.s_turn = st; r.s_resp = sr;
			r.count = 7'(k + 1);
			r.last = (k + 1 == batch_len);
			finished[best] = 1'b1;
			tick = r.finish;
			pending_recs.insert(pending_recs.size(), r);
		end
		batch_len = 0;
		batches_run++;
	endfunction

	function automatic void load_job(logic [15:0] id, logic [15:0] arr, logic [15:0] bl,
			logic [7:0] pr, logic fin);
		// A job offered to a full table is dropped.
		if (batch_len < MAX_JOBS) begin
			batch_id[batch_len] = id;
			batch_arr[batch_len] = arr;
			batch_burst[batch_len] = bl;
			batch_prio[batch_len] = pr;
			batch_len++;
		end
		if (fin)
			schedule_batch();
	endfunction

	// Offers one job and returns after the transaction; valid stays high
	// unless the next call idles or the sender waits for the results.
	task automatic send_job(logic [15:0] id, logic [15:0] arr, logic [15:0] bl,
			logic [7:0] pr, logic fin);
		bit rdy;
		if (!send_busy_free && $urandom_range(0, 99) < 37) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		job_id <= id;
		arrival_time <= arr;
		burst_length <= bl;
		priority_level <= pr;
		final_job <= fin;
		do begin
			@(negedge clk);
			rdy = in_ready;
			@(posedge clk);
		end while (!rdy);
		load_job(id, arr, bl, pr, fin);
		jobs_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_recs.size() != 0);
	endtask

	task automatic send_random_batch(int n, int mode);
		logic [15:0] arr;
		for (int i = 0; i < n; i++) begin
			case (mode)
				0: arr = 16'($urandom_range(0, 40));
				1: arr = 16'($urandom);
				default: arr = 16'($urandom_range(0, 3) * 1000);
			endcase
			send_job(16'($urandom), arr,
				(mode == 1) ? 16'($urandom) : 16'($urandom_range(0, 30)),
				($urandom_range(0, 1)) ? 8'($urandom) : 8'($urandom_range(0, 3)),
				i == n - 1);
		end
	endtask

	task automatic test_directed();
		// Single job, everything zero.
		send_job(16'h0000, 16'h0000, 16'h0000, 8'h00, 1'b1);
		// Field maxima in one job, then a late arrival that forces a time jump.
		send_job(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1);
		send_job(16'h0010, 16'd500, 16'd7, 8'd3, 1'b0);
		send_job(16'h0011, 16'd100, 16'd0, 8'd9, 1'b1);
		// Priority ties settled by arrival, then by load order.
		send_job(16'h0020, 16'd5, 16'd4, 8'd2, 1'b0);
		send_job(16'h0021, 16'd2, 16'd4, 8'd2, 1'b0);
		send_job(16'h0022, 16'd2, 16'd4, 8'd2, 1'b0);
		send_job(16'h0023, 16'd0, 16'd10, 8'd7, 1'b1);
		wait_drained();
	endtask

	task automatic test_table_full();
		// Seventeen jobs: the last is dropped but still starts the schedule.
		for (int i = 0; i <= MAX_JOBS; i++)
			send_job(16'(16'h0100 + i), 16'($urandom_range(0, 60)),
				16'($urandom_range(0, 9)), 8'($urandom_range(0, 4)), i == MAX_JOBS);
		wait_drained();
	endtask

	task automatic test_output_stall();
		// The receiver stops while two full batches are offered back to back.
		stall_cycles = 400;
		send_busy_free = 1'b1;
		send_random_batch(MAX_JOBS, 0);
		send_random_batch(MAX_JOBS, 2);
		send_busy_free = 1'b0;
		wait_drained();
	endtask

	task automatic test_random(int target);
		int n, mode;
		while (jobs_sent < target) begin
			// A stretch in the middle runs with no idling on either side.
			send_busy_free = (jobs_sent > target / 2 && jobs_sent < target / 2 + 40);
			recv_busy_free = send_busy_free;
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(MAX_JOBS, MAX_JOBS + 2)
				: $urandom_range(1, 6);
			mode = $urandom_range(0, 2);
			send_random_batch(n, mode);
		end
		send_busy_free = 1'b0;
		recv_busy_free = 1'b0;
	endtask

	// Receiver side.
	always @(posedge clk) begin
		if (stall_cycles > 0) begin
			out_ready <= 1'b0;
			stall_cycles <= stall_cycles - 1;
		end else if (recv_busy_free)
			out_ready <= 1'b1;
		else
			out_ready <= ($urandom_range(0, 99) >= 37);
	end

	function automatic void check_field(string name, logic [27:0] exp_v, logic [27:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, exp_v, act_v);
			errors++;
		end
	endfunction

	// Payload is compared at the falling edge before the accepting rising edge.
	always @(negedge clk) begin
		sched_rec_t e;
		if (arst_n && out_valid && out_ready) begin
			recs_seen++;
			if (pending_recs.size() == 0) begin
				$display("%0t: unexpected record, job %0d", $realtime, job_id_res);
				errors++;
			end else begin
				e = pending_recs.pop_front();
				check_field("job_id_res", 28'(e.id), 28'(job_id_res));
				check_field("start_time", 28'(e.start), 28'(start_time));
				check_field("finish_time", 28'(e.finish), 28'(finish_time));
				check_field("wait_time", 28'(e.wait_t), 28'(wait_time));
				check_field("turnaround", 28'(e.turn), 28'(turnaround));
				check_field("response", 28'(e.resp), 28'(response));
				check_field("sum_wait", e.s_wait, sum_wait);
				check_field("sum_turnaround", e.s_turn, sum_turnaround);
				check_field("sum_response", e.s_resp, sum_response);
				check_field("job_count", 28'(e.count), 28'(job_count));
				check_field("last_record", 28'(e.last), 28'(last_record));
			end
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_table_full();
		test_output_stall();
		test_random(280);
		wait_drained();
		repeat (100) @(posedge clk);
		if (pending_recs.size() != 0)
			errors++;
		$display("Ran %0d jobs in %0d schedules, %0d records checked,", jobs_sent,
			batches_run, recs_seen);
		$display("including full tables, dropped jobs, time jumps and output stalls.");
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#5ms;
		$display("Timeout with %0d records outstanding", pending_recs.size());
		$display("== FAIL ==");
		$finish;
	end
endmodule

// ===== filelist.f =====
+incdir+sv
sv/nps_pkg.sv
sv/nps_cell.sv
sv/nps_pick.sv
sv/nonpreemptive_priority_scheduler.sv
verif/tb_nonpreemptive_priority_scheduler.sv
